[rtl/dsm_pkg.sv]
// Shared types and codes for the dual stack shared memory unit.
package dsm_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FillW = 8;

  typedef enum logic [2:0] {
    CMD_PUSH_ONE = 3'd0,
    CMD_PUSH_TWO = 3'd1,
    CMD_POP_ONE  = 3'd2,
    CMD_POP_TWO  = 3'd3,
    CMD_PEEK_ONE = 3'd4,
    CMD_PEEK_TWO = 3'd5
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_code_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // request taken: update pointers, start memory access
    logic capture;  // read data ready: load the result register
  } dsm_ctl_t;

endpackage

[rtl/dsm_ctrl.sv]
// Request sequencer for the dual stack shared memory unit.
module dsm_ctrl
  import dsm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dsm_ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_DONE  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctl.accept  = 1'b0;
    ctl.capture = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && !rst) begin
          ctl.accept = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        ctl.capture = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // no request is taken while reset is held
  assign in_stall  = rst || (state != S_IDLE);
  assign out_valid = (state == S_DONE);

endmodule

[rtl/dsm_datapath.sv]
// Stack pointers, shared word memory and result register.
module dsm_datapath
  import dsm_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dsm_ctl_t                ctl,
  input  logic [2:0]              cmd,
  input  logic signed [WordW-1:0] push_value,
  output logic signed [WordW-1:0] result_value,
  output logic [1:0]              status,
  output logic [FillW-1:0]        fill_one,
  output logic [FillW-1:0]        fill_two
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] TopCount = CW'(DEPTH);

  logic [WordW-1:0] mem [DEPTH];
  logic [WordW-1:0] rd_data;

  logic [CW-1:0] lower_count;
  logic [CW-1:0] lower_count_next;
  logic [CW-1:0] upper_boundary;
  logic [CW-1:0] upper_boundary_next;

  logic          full;
  logic          one_empty;
  logic          two_empty;
  logic          wr_en;
  logic          rd_en;
  logic [CW-1:0] wr_ptr;
  logic [CW-1:0] rd_ptr;
  logic [1:0]    stat_next;
  logic [1:0]    stat_held;
  logic          has_word;
  logic          has_word_next;

  logic [CW+FillW-1:0] fill_one_ext;
  logic [CW+FillW-1:0] fill_two_ext;

  assign full      = (lower_count >= upper_boundary);
  assign one_empty = (lower_count == '0);
  assign two_empty = (upper_boundary >= TopCount);

  always_comb begin
    lower_count_next    = lower_count;
    upper_boundary_next = upper_boundary;
    wr_en               = 1'b0;
    rd_en               = 1'b0;
    wr_ptr              = lower_count;
    rd_ptr              = upper_boundary;
    stat_next           = ST_OK;
    has_word_next       = 1'b0;
    case (cmd)
      CMD_PUSH_ONE: begin
        if (full) begin
          stat_next = ST_OVERFLOW;
        end else begin
          wr_en            = 1'b1;
          wr_ptr           = lower_count;
          lower_count_next = lower_count + 1'b1;
        end
      end
      CMD_PUSH_TWO: begin
        if (full) begin
          stat_next = ST_OVERFLOW;
        end else begin
          wr_en               = 1'b1;
          wr_ptr              = upper_boundary - 1'b1;
          upper_boundary_next = upper_boundary - 1'b1;
        end
      end
      CMD_POP_ONE: begin
        if (one_empty) begin
          stat_next = ST_UNDERFLOW;
        end else begin
          rd_en            = 1'b1;
          has_word_next    = 1'b1;
          rd_ptr           = lower_count - 1'b1;
          lower_count_next = lower_count - 1'b1;
        end
      end
      CMD_POP_TWO: begin
        if (two_empty) begin
          stat_next = ST_UNDERFLOW;
        end else begin
          rd_en               = 1'b1;
          has_word_next       = 1'b1;
          rd_ptr              = upper_boundary;
          upper_boundary_next = upper_boundary + 1'b1;
        end
      end
      CMD_PEEK_ONE: begin
        if (one_empty) begin
          stat_next = ST_UNDERFLOW;
        end else begin
          rd_en         = 1'b1;
          has_word_next = 1'b1;
          rd_ptr        = lower_count - 1'b1;
        end
      end
      CMD_PEEK_TWO: begin
        if (two_empty) begin
          stat_next = ST_UNDERFLOW;
        end else begin
          rd_en         = 1'b1;
          has_word_next = 1'b1;
          rd_ptr        = upper_boundary;
        end
      end
      default: begin
        stat_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && wr_en) begin
      mem[wr_ptr[AW-1:0]] <= $unsigned(push_value);
    end
    if (ctl.accept && rd_en) begin
      rd_data <= mem[rd_ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_count    <= '0;
      upper_boundary <= TopCount;
    end else if (ctl.accept) begin
      lower_count    <= lower_count_next;
      upper_boundary <= upper_boundary_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      stat_held <= stat_next;
      has_word  <= has_word_next;
    end
  end

  // counters already hold the post-request values at capture time
  assign fill_one_ext = {{FillW{1'b0}}, lower_count};
  assign fill_two_ext = {{FillW{1'b0}}, TopCount - upper_boundary};

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      result_value <= has_word ? $signed(rd_data) : '0;
      status       <= stat_held;
      fill_one     <= fill_one_ext[FillW-1:0];
      fill_two     <= fill_two_ext[FillW-1:0];
    end
  end

endmodule

[rtl/dual_stack_shared_memory_unit.sv]
// Top level: two stacks sharing one word memory, sequencer plus datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  request  | in_valid / in_stall  | cmd, push_value
//  result   | out_valid / out_stall| result_value, status, fill_one, fill_two
//
// A request is handled in order: accept (pointer update, memory access),
// read data capture into the result register, then the result is offered.
// Capture is a state of its own because the memory read is synchronous.
// Reset empties both stacks and holds in_stall high; memory is left as is.
// in_stall stays high from acceptance until the result is taken; a stalled
// result holds.
module dual_stack_shared_memory_unit
  import dsm_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              cmd,
  input  logic signed [WordW-1:0] push_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [WordW-1:0] result_value,
  output logic [1:0]              status,
  output logic [FillW-1:0]        fill_one,
  output logic [FillW-1:0]        fill_two
);

  dsm_ctl_t ctl;

  dsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  dsm_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cmd          (cmd),
    .push_value   (push_value),
    .result_value (result_value),
    .status       (status),
    .fill_one     (fill_one),
    .fill_two     (fill_two)
  );

endmodule
